// ----- rtl/stq_pkg.sv -----
// Package with shared request and response types and command/status codes.
`timescale 1ns / 1ps

package stq_pkg;

   localparam logic [2:0] CMD_INSERT   = 3'd0;
   localparam logic [2:0] CMD_LOOKUP   = 3'd1;
   localparam logic [2:0] CMD_REMOVE   = 3'd2;
   localparam logic [2:0] CMD_POP      = 3'd3;
   localparam logic [2:0] CMD_RETRIEVE = 3'd4;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_MISS     = 2'd1;
   localparam logic [1:0] STS_FULL     = 2'd2;

   localparam int VALUE_W = 32;

   typedef struct packed {
      logic [2:0]                command;
      logic signed [VALUE_W-1:0] value;
      logic [5:0]                position;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] result_value;
      logic [5:0]                found_index;
      logic [6:0]                entry_count;
   } rsp_type;

endpackage

// ----- rtl/stq_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module stq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sorted_table_engine.sv -----
// Top level: sorted table of signed values kept in one RAM, with search and shift sequencer.
// Takes one request at a time; req_ready is high only while the sequencer is idle.
// Lookup runs a binary search, then a fetch and compare; retrieve fetches the entry by position.
// Insert/remove/pop move entries one at a time through the single RAM read and write port.
// The response register frees the sequencer for the next request while a response waits.
// Synchronous reset empties the table (count zero); RAM contents are not cleared.
`timescale 1ns / 1ps

module sorted_table_engine #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SCMP,
      S_FETCH,
      S_FCHK,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type                         state_ff;
   logic [CW-1:0]                     count_ff;
   logic [2:0]                        cmd_ff;
   logic signed [stq_pkg::VALUE_W-1:0] val_ff;
   logic [CW-1:0]                     lo_ff;
   logic [CW-1:0]                     hi_ff;
   logic [CW-1:0]                     mid_ff;
   logic [CW-1:0]                     p_ff;
   logic [CW-1:0]                     src_ff;
   logic [CW-1:0]                     rem_ff;
   logic                              up_ff;
   logic                              pend_ff;
   logic [CW-1:0]                     pend_src_ff;
   logic [1:0]                        status_ff;
   logic signed [stq_pkg::VALUE_W-1:0] rval_ff;
   logic [5:0]                        fidx_ff;
   logic                              rsp_valid_ff;
   stq_pkg::rsp_type                  rsp_ff;

   logic [CW-1:0]                     mid_w;
   logic                              ent_lt;
   logic                              ent_eq;
   logic                              go_right;
   logic                              pos_ok;

   logic                              ram_wr_en;
   logic [AW-1:0]                     ram_wr_addr;
   logic [stq_pkg::VALUE_W-1:0]       ram_wr_data;
   logic                              ram_rd_en;
   logic [AW-1:0]                     ram_rd_addr;
   logic [stq_pkg::VALUE_W-1:0]       ram_rd_data;

   stq_ram #(
      .WIDTH(stq_pkg::VALUE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign mid_w    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign ent_lt   = $signed(ram_rd_data) < val_ff;
   assign ent_eq   = ram_rd_data == val_ff;
   // insert seeks past equals, lookup and remove stop at the first equal
   assign go_right = (cmd_ff == stq_pkg::CMD_INSERT) ? (ent_lt | ent_eq) : ent_lt;
   assign pos_ok   = (XW'(req_data.position) < XW'(count_ff)) &&
                     (XW'(req_data.position) < XW'(DEPTH));

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(mid_w);
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(p_ff);
      ram_wr_data = ram_rd_data;
      case (state_ff)
         S_SEARCH: begin
            ram_rd_en   = lo_ff < hi_ff;
            ram_rd_addr = AW'(mid_w);
         end
         S_FETCH: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(p_ff);
         end
         S_SHIFT: begin
            ram_rd_en   = rem_ff != '0;
            ram_rd_addr = AW'(src_ff);
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = up_ff ? AW'(pend_src_ff + ONE_C) : AW'(pend_src_ff - ONE_C);
               ram_wr_data = ram_rd_data;
            end else if (rem_ff == '0 && up_ff) begin
               // drop the new value into the opened slot
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(p_ff);
               ram_wr_data = val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff    <= req_data.command;
                  val_ff    <= req_data.value;
                  status_ff <= stq_pkg::STS_MISS;
                  rval_ff   <= '0;
                  fidx_ff   <= '0;
                  lo_ff     <= '0;
                  hi_ff     <= count_ff;
                  p_ff      <= '0;
                  case (req_data.command)
                     stq_pkg::CMD_INSERT: begin
                        if (count_ff == DEPTH_C) begin
                           status_ff <= stq_pkg::STS_FULL;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_SEARCH;
                        end
                     end
                     stq_pkg::CMD_LOOKUP,
                     stq_pkg::CMD_REMOVE: begin
                        state_ff <= S_SEARCH;
                     end
                     stq_pkg::CMD_POP: begin
                        state_ff <= (count_ff != '0) ? S_FETCH : S_RESP;
                     end
                     stq_pkg::CMD_RETRIEVE: begin
                        p_ff     <= CW'(req_data.position);
                        state_ff <= pos_ok ? S_FETCH : S_RESP;
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            S_SEARCH: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_w;
                  state_ff <= S_SCMP;
               end else begin
                  p_ff <= lo_ff;
                  if (cmd_ff == stq_pkg::CMD_INSERT) begin
                     up_ff    <= 1'b1;
                     pend_ff  <= 1'b0;
                     src_ff   <= count_ff - ONE_C;
                     rem_ff   <= count_ff - lo_ff;
                     state_ff <= S_SHIFT;
                  end else begin
                     state_ff <= (lo_ff < count_ff) ? S_FETCH : S_RESP;
                  end
               end
            end
            S_SCMP: begin
               if (go_right) begin
                  lo_ff <= mid_ff + ONE_C;
               end else begin
                  hi_ff <= mid_ff;
               end
               state_ff <= S_SEARCH;
            end
            S_FETCH: begin
               state_ff <= S_FCHK;
            end
            S_FCHK: begin
               // set up a down shift that closes the gap at p
               up_ff   <= 1'b0;
               pend_ff <= 1'b0;
               src_ff  <= p_ff + ONE_C;
               rem_ff  <= count_ff - p_ff - ONE_C;
               case (cmd_ff)
                  stq_pkg::CMD_LOOKUP: begin
                     if (ent_eq) begin
                        status_ff <= stq_pkg::STS_OK;
                        fidx_ff   <= 6'(p_ff);
                     end
                     state_ff <= S_RESP;
                  end
                  stq_pkg::CMD_REMOVE: begin
                     if (ent_eq) begin
                        status_ff <= stq_pkg::STS_OK;
                        state_ff  <= S_SHIFT;
                     end else begin
                        state_ff <= S_RESP;
                     end
                  end
                  stq_pkg::CMD_POP: begin
                     status_ff <= stq_pkg::STS_OK;
                     rval_ff   <= $signed(ram_rd_data);
                     state_ff  <= S_SHIFT;
                  end
                  default: begin
                     status_ff <= stq_pkg::STS_OK;
                     rval_ff   <= $signed(ram_rd_data);
                     state_ff  <= S_RESP;
                  end
               endcase
            end
            S_SHIFT: begin
               if (rem_ff != '0) begin
                  src_ff      <= up_ff ? (src_ff - ONE_C) : (src_ff + ONE_C);
                  rem_ff      <= rem_ff - ONE_C;
                  pend_ff     <= 1'b1;
                  pend_src_ff <= src_ff;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     if (up_ff) begin
                        count_ff  <= count_ff + ONE_C;
                        status_ff <= stq_pkg::STS_OK;
                     end else begin
                        count_ff <= count_ff - ONE_C;
                     end
                     state_ff <= S_RESP;
                  end
               end
            end
            S_RESP: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.status       <= status_ff;
                  rsp_ff.result_value <= rval_ff;
                  rsp_ff.found_index  <= fidx_ff;
                  rsp_ff.entry_count  <= 7'(count_ff);
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/stq_chk.sv -----
// Port-level checker for the sorted table engine, bound to the top level.
`timescale 1ns / 1ps

module stq_chk #(
   parameter int DEPTH = 64
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input stq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input stq_pkg::rsp_type rsp_data
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one request in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in flight");

   // a failed request returns zero value and index
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != stq_pkg::STS_OK |->
         rsp_data.result_value == '0 && rsp_data.found_index == '0)
      else $error("failed response carries nonzero data");

   // full status only with a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == stq_pkg::STS_FULL |->
         rsp_data.entry_count == 7'(DEPTH))
      else $error("full status with table not full");

endmodule

bind sorted_table_engine stq_chk #(.DEPTH(DEPTH)) u_stq_chk (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
